>>> hw/rtl/cxalu_pkg.sv
// cxalu_pkg: shared types and constants of the checked complex integer alu
// no dependencies; imported by the channel interfaces, the divider and the top level
package cxalu_pkg;

    // field widths that do not follow the data width
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // divider lanes: real and imaginary quotient
    localparam int LANES   = 2;
    localparam int LANE_RE = 0;
    localparam int LANE_IM = 1;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // control that rides along the divider pipeline
    typedef struct packed {
        logic    neg_re;
        logic    neg_im;
        status_t status;
    } ctl_t;

endpackage

>>> hw/rtl/cxalu_if.sv
// cxalu_if: valid/ready channel interfaces for operation words and result words
// depends on cxalu_pkg for the command and status field widths
interface cxalu_in_if
    import cxalu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;

    modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cxalu_out_if
    import cxalu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic [STATUS_W-1:0]          status;

    modport source (output valid, res_real, res_imag, status, input ready);
    modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

>>> hw/rtl/cxalu_div.sv
// cxalu_div: pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage
// depends on cxalu_pkg for the lane count and the control struct
module cxalu_div
    import cxalu_pkg::*;
#(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     num [LANES],
    input  logic [2*W-1:0]   den,
    input  ctl_t             in_ctl,
    output logic             out_valid,
    output logic [W-1:0]     q [LANES],
    output ctl_t             out_ctl
);

    // stage registers
    logic [W-1:0]   num_reg [W][LANES];
    logic [W-1:0]   rem_reg [W][LANES];
    logic [W-1:0]   q_reg   [W][LANES];
    logic [2*W-1:0] den_reg [W];
    ctl_t           ctl_reg [W];
    logic [W-1:0]   v_reg;

    // stage inputs
    logic [W-1:0]   num_src [W][LANES];
    logic [W-1:0]   rem_src [W][LANES];
    logic [W-1:0]   q_src   [W][LANES];
    logic [2*W-1:0] den_src [W];
    ctl_t           ctl_src [W];
    logic [W-1:0]   v_src;

    for (genvar k = 0; k < W; k++) begin : g_stage
        // stage source: module inputs for the head, previous stage otherwise
        if (k == 0) begin : g_head
            assign den_src[k] = den;
            assign ctl_src[k] = in_ctl;
            assign v_src[k]   = in_valid;
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign num_src[k][l] = num[l];
                assign rem_src[k][l] = '0;
                assign q_src[k][l]   = '0;
            end
        end else begin : g_body
            assign den_src[k] = den_reg[k-1];
            assign ctl_src[k] = ctl_reg[k-1];
            assign v_src[k]   = v_reg[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign num_src[k][l] = num_reg[k-1][l];
                assign rem_src[k][l] = rem_reg[k-1][l];
                assign q_src[k][l]   = q_reg[k-1][l];
            end
        end

        // valid bit of the stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src[k];
            end
        end

        // shared divisor and control
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_src[k];
                ctl_reg[k] <= ctl_src[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [W-1:0] shift_next;
            logic         fits_next;
            logic [W-1:0] rem_next;
            logic [W-1:0] q_next;
            logic [W-1:0] num_next;

            // bring down the next numerator bit, subtract if the divisor fits
            assign shift_next = {rem_src[k][l][W-2:0], num_src[k][l][W-1]};
            assign fits_next  = {{W{1'b0}}, shift_next} >= den_src[k];
            assign rem_next   = fits_next ? shift_next - den_src[k][W-1:0] : shift_next;
            assign q_next     = {q_src[k][l][W-2:0], fits_next};
            assign num_next   = {num_src[k][l][W-2:0], 1'b0};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k][l] <= num_next;
                    rem_reg[k][l] <= rem_next;
                    q_reg[k][l]   <= q_next;
                end
            end
        end
    end

    // last stage holds the finished quotients
    assign out_valid = v_reg[W-1];
    assign out_ctl   = ctl_reg[W-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign q[l] = q_reg[W-1][l];
    end

endmodule

>>> hw/rtl/checked_complex_int_alu.sv
// checked_complex_int_alu: complex add, subtract, multiply and divide with overflow check
// depends on cxalu_pkg, cxalu_if (cxalu_in_if, cxalu_out_if) and cxalu_div
// throughput: one word per cycle while the skid buffer is empty
// the stages are the input register, product stage, sum/check stage, DATA_WIDTH divider
//   stages (one quotient bit each) and an output register
// a one-word skid buffer behind the output register absorbs a stalled result
// reset clears all valid bits and the skid buffer; no payload state is kept
module checked_complex_int_alu
    import cxalu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    cxalu_in_if.sink     req,
    cxalu_out_if.source  rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = 2 * W + 1;

    // pipeline advance, stops only while the skid buffer is full
    logic adv;
    logic skid_v_reg;

    assign adv       = !skid_v_reg;
    assign req.ready = adv;

    // stage 1: input registers
    logic                s1_v_reg;
    cmd_t                s1_cmd_reg;
    logic signed [W-1:0] s1_ar_reg;
    logic signed [W-1:0] s1_ai_reg;
    logic signed [W-1:0] s1_br_reg;
    logic signed [W-1:0] s1_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= cmd_t'(req.cmd);
            s1_ar_reg  <= req.a_real;
            s1_ai_reg  <= req.a_imag;
            s1_br_reg  <= req.b_real;
            s1_bi_reg  <= req.b_imag;
        end
    end

    // stage 2: exact products
    logic signed [PW-1:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next, sq_r_next, sq_i_next;

    assign p_rr_next = PW'(s1_ar_reg) * PW'(s1_br_reg);
    assign p_ii_next = PW'(s1_ai_reg) * PW'(s1_bi_reg);
    assign p_ri_next = PW'(s1_ar_reg) * PW'(s1_bi_reg);
    assign p_ir_next = PW'(s1_ai_reg) * PW'(s1_br_reg);
    assign sq_r_next = PW'(s1_br_reg) * PW'(s1_br_reg);
    assign sq_i_next = PW'(s1_bi_reg) * PW'(s1_bi_reg);

    logic                 s2_v_reg;
    cmd_t                 s2_cmd_reg;
    logic signed [W-1:0]  s2_ar_reg, s2_ai_reg, s2_br_reg, s2_bi_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_ar_reg  <= s1_ar_reg;
            s2_ai_reg  <= s1_ai_reg;
            s2_br_reg  <= s1_br_reg;
            s2_bi_reg  <= s1_bi_reg;
            p_rr_reg   <= p_rr_next;
            p_ii_reg   <= p_ii_next;
            p_ri_reg   <= p_ri_next;
            p_ir_reg   <= p_ir_next;
            sq_r_reg   <= sq_r_next;
            sq_i_reg   <= sq_i_next;
        end
    end

    // stage 3: operand select, final sums, range check, divisor
    logic signed [XW-1:0] lhs_re, rhs_re, lhs_im, rhs_im, sum_re, sum_im;
    logic                 sub_re, sub_im;
    logic [XW-W:0]        top_re, top_im;
    logic                 fit_re, fit_im, is_div, divz;
    logic [PW-1:0]        den_sq;
    status_t              status_next;

    always_comb
    begin
        lhs_re = XW'(s2_ar_reg);
        rhs_re = XW'(s2_br_reg);
        lhs_im = XW'(s2_ai_reg);
        rhs_im = XW'(s2_bi_reg);
        sub_re = 1'b0;
        sub_im = 1'b0;
        unique case (s2_cmd_reg)
            CMD_ADD:
            begin
                sub_re = 1'b0;
                sub_im = 1'b0;
            end
            CMD_SUB:
            begin
                sub_re = 1'b1;
                sub_im = 1'b1;
            end
            CMD_MUL:
            begin
                lhs_re = XW'(p_rr_reg);
                rhs_re = XW'(p_ii_reg);
                sub_re = 1'b1;
                lhs_im = XW'(p_ri_reg);
                rhs_im = XW'(p_ir_reg);
                sub_im = 1'b0;
            end
            CMD_DIV:
            begin
                lhs_re = XW'(p_rr_reg);
                rhs_re = XW'(p_ii_reg);
                sub_re = 1'b0;
                lhs_im = XW'(p_ir_reg);
                rhs_im = XW'(p_ri_reg);
                sub_im = 1'b1;
            end
            default:
            begin
                sub_re = 1'b0;
                sub_im = 1'b0;
            end
        endcase
        sum_re = sub_re ? lhs_re - rhs_re : lhs_re + rhs_re;
        sum_im = sub_im ? lhs_im - rhs_im : lhs_im + rhs_im;
    end

    // fits in W signed bits when all bits from the sign bit up agree
    assign top_re = sum_re[XW-1:W-1];
    assign top_im = sum_im[XW-1:W-1];
    assign fit_re = (top_re == '0) || (top_re == '1);
    assign fit_im = (top_im == '0) || (top_im == '1);

    assign is_div = (s2_cmd_reg == CMD_DIV);
    assign divz   = is_div && (s2_br_reg == '0) && (s2_bi_reg == '0);
    assign den_sq = sq_r_reg[PW-1:0] + sq_i_reg[PW-1:0];

    always_comb
    begin
        if (divz)
        begin
            status_next = ST_DIVZ;
        end
        else if (!fit_re || !fit_im)
        begin
            status_next = ST_OVF;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    logic          s3_v_reg;
    logic [W-1:0]  s3_re_reg, s3_im_reg;
    logic [PW-1:0] s3_den_reg;
    status_t       s3_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    // non-divide and zero-divisor words go through the divider with a divisor of one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_re_reg     <= sum_re[W-1:0];
            s3_im_reg     <= sum_im[W-1:0];
            s3_den_reg    <= (is_div && !divz) ? den_sq : PW'(1);
            s3_status_reg <= status_next;
        end
    end

    // magnitudes and signs into the divider, zero on error
    logic         s3_err;
    logic [W-1:0] mag [LANES];
    ctl_t         div_in_ctl;

    assign s3_err = (s3_status_reg != ST_OK);

    always_comb
    begin
        mag[LANE_RE] = s3_re_reg[W-1] ? W'(~s3_re_reg + W'(1)) : s3_re_reg;
        mag[LANE_IM] = s3_im_reg[W-1] ? W'(~s3_im_reg + W'(1)) : s3_im_reg;
        if (s3_err)
        begin
            mag[LANE_RE] = '0;
            mag[LANE_IM] = '0;
        end
        div_in_ctl.neg_re = s3_re_reg[W-1];
        div_in_ctl.neg_im = s3_im_reg[W-1];
        div_in_ctl.status = s3_status_reg;
    end

    // divider pipeline
    logic         dv_valid;
    logic [W-1:0] dv_q [LANES];
    ctl_t         dv_ctl;

    cxalu_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_v_reg),
        .num       (mag),
        .den       (s3_den_reg),
        .in_ctl    (div_in_ctl),
        .out_valid (dv_valid),
        .q         (dv_q),
        .out_ctl   (dv_ctl)
    );

    // restore signs
    logic [W-1:0] fin_re, fin_im;

    assign fin_re = dv_ctl.neg_re ? W'(~dv_q[LANE_RE] + W'(1)) : dv_q[LANE_RE];
    assign fin_im = dv_ctl.neg_im ? W'(~dv_q[LANE_IM] + W'(1)) : dv_q[LANE_IM];

    // output register and skid buffer
    logic         out_v_reg;
    logic [W-1:0] out_re_reg, out_im_reg;
    status_t      out_st_reg;
    logic [W-1:0] skid_re_reg, skid_im_reg;
    status_t      skid_st_reg;
    logic         out_free;
    logic         out_v_next, skid_v_next;
    logic         out_load, out_from_skid, skid_load;

    assign out_free = !out_v_reg || rsp.ready;

    always_comb
    begin
        out_v_next    = out_v_reg;
        skid_v_next   = skid_v_reg;
        out_load      = 1'b0;
        out_from_skid = 1'b0;
        skid_load     = 1'b0;
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_next    = 1'b1;
                out_load      = 1'b1;
                out_from_skid = 1'b1;
                skid_v_next   = 1'b0;
            end
            else
            begin
                out_v_next = dv_valid;
                out_load   = dv_valid;
            end
        end
        else if (adv && dv_valid)
        begin
            skid_v_next = 1'b1;
            skid_load   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg <= out_from_skid ? skid_re_reg : fin_re;
            out_im_reg <= out_from_skid ? skid_im_reg : fin_im;
            out_st_reg <= out_from_skid ? skid_st_reg : dv_ctl.status;
        end
        if (skid_load)
        begin
            skid_re_reg <= fin_re;
            skid_im_reg <= fin_im;
            skid_st_reg <= dv_ctl.status;
        end
    end

    assign rsp.valid    = out_v_reg;
    assign rsp.res_real = out_re_reg;
    assign rsp.res_imag = out_im_reg;
    assign rsp.status   = out_st_reg;

    // an error result carries zero parts
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.res_real == '0 && rsp.res_imag == '0))
        else $error("error result with nonzero parts");

    // the skid buffer only fills behind a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(rsp.valid && !rsp.ready))
        else $error("skid buffer filled without an output stall");

    // a full skid buffer always sits behind a valid output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid buffer full while output register empty");

    // a divide by zero word goes through the divider with a unit divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && (s3_status_reg == ST_DIVZ)) |-> (s3_den_reg == PW'(1)))
        else $error("divide by zero word entered the divider without a unit divisor");

endmodule
